>>> rtl/core/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication, consequent may be a sequence
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stt_pkg.sv
// shared types, constants and character-class functions for the tokenizer
// no dependencies; used by stt_step, stt_outq and source_text_tokenizer
package stt_pkg;

  localparam int LINE_BITS = 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

  // result queue geometry
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [7:0] COMMENT_RESET = 8'd47;

  // characters the scanner reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;

  // token kinds
  localparam logic [3:0] KIND_NUM   = 4'd0;
  localparam logic [3:0] KIND_ID    = 4'd1;
  localparam logic [3:0] KIND_STR   = 4'd2;
  localparam logic [3:0] KIND_EQ    = 4'd3;
  localparam logic [3:0] KIND_SEMI  = 4'd4;
  localparam logic [3:0] KIND_LPAR  = 4'd5;
  localparam logic [3:0] KIND_RPAR  = 4'd6;
  localparam logic [3:0] KIND_STAR  = 4'd7;
  localparam logic [3:0] KIND_BANG  = 4'd8;
  localparam logic [3:0] KIND_QMARK = 4'd9;
  localparam logic [3:0] KIND_COMMA = 4'd10;
  localparam logic [3:0] KIND_PLUS  = 4'd11;
  localparam logic [3:0] KIND_END   = 4'd12;

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DOT   = 2'd1;
  localparam logic [1:0] FAULT_MINUS = 2'd2;
  localparam logic [1:0] FAULT_STR   = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_ID,
    MODE_STR,
    MODE_HELD,
    MODE_CMT,
    MODE_HALT
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic                 dot;
    logic                 minus;
    logic [LINE_BITS-1:0] line;
  } scan_st_t;

  // one result word
  typedef struct packed {
    logic [3:0]           kind;
    logic [7:0]           ch;
    logic                 start;
    logic                 tok_end;
    logic [LINE_BITS-1:0] line;
    logic [1:0]           fault;
  } tok_t;

  // outcome of one character seen between tokens
  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic [7:0] ch;
    logic       tok_end;
    mode_t      mode;
    logic       num_start;
    logic       minus_first;
    logic       newline;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LC_LO) && (c <= CH_LC_HI)) ||
           ((c >= CH_UC_LO) && (c <= CH_UC_HI));
  endfunction

  // KIND_NUM doubles as "not a punctuator"
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_EQ:    k = KIND_EQ;
      CH_SEMI:  k = KIND_SEMI;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      CH_STAR:  k = KIND_STAR;
      CH_BANG:  k = KIND_BANG;
      CH_QMARK: k = KIND_QMARK;
      CH_COMMA: k = KIND_COMMA;
      CH_PLUS:  k = KIND_PLUS;
      default:  k = KIND_NUM;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [7:0] ch,
                                  input logic st, input logic en,
                                  input logic [LINE_BITS-1:0] ln, input logic [1:0] flt);
    tok_t t;
    t.kind    = kind;
    t.ch      = ch;
    t.start   = st;
    t.tok_end = en;
    t.line    = ln;
    t.fault   = flt;
    return t;
  endfunction

  // classify a non-zero character between tokens
  function automatic idle_t idle_step(input logic [7:0] c, input logic cmt_ok,
                                      input logic [7:0] cmt_ch);
    idle_t      r;
    logic [3:0] pk;
    r      = '0;
    r.mode = MODE_IDLE;
    pk     = punct_kind(c);
    priority if (cmt_ok && (c == cmt_ch)) begin
      r.mode = MODE_HELD;
    end else if ((c == CH_SPACE) || (c == CH_CR)) begin
      r.emit = 1'b0;
    end else if (c == CH_LF) begin
      r.newline = 1'b1;
    end else if (is_digit(c) || (c == CH_MINUS)) begin
      r.emit        = 1'b1;
      r.kind        = KIND_NUM;
      r.ch          = c;
      r.mode        = MODE_NUM;
      r.num_start   = 1'b1;
      r.minus_first = (c == CH_MINUS);
    end else if (is_alnum(c)) begin
      r.emit = 1'b1;
      r.kind = KIND_ID;
      r.ch   = c;
      r.mode = MODE_ID;
    end else if (c == CH_QUOTE) begin
      r.emit = 1'b1;
      r.kind = KIND_STR;
      r.ch   = c;
      r.mode = MODE_STR;
    end else if (pk != KIND_NUM) begin
      r.emit    = 1'b1;
      r.kind    = pk;
      r.ch      = c;
      r.tok_end = 1'b1;
    end else begin
      // unknown character: end of text, then ignore input
      r.emit    = 1'b1;
      r.kind    = KIND_END;
      r.ch      = CH_NUL;
      r.tok_end = 1'b1;
      r.mode    = MODE_HALT;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/stt_step.sv
// next-state and result logic for one source byte (purely combinational)
// depends on stt_pkg; up to two result words per byte
module stt_step import stt_pkg::*; (
  input  scan_st_t   st_i,
  input  logic [7:0] char_i,
  input  logic [7:0] cmt_ch_i,
  output scan_st_t   st_o,
  output logic [1:0] res_n_o,
  output tok_t       res0_o,
  output tok_t       res1_o
);

  mode_t                md;
  logic                 dot;
  logic                 mns;
  logic [LINE_BITS-1:0] ln;
  logic [1:0]           n;
  tok_t                 r0;
  tok_t                 r1;
  tok_t                 t;
  idle_t                ia;
  idle_t                ib;
  logic                 swallow;
  logic                 run_idle;
  logic [3:0]           open_kind;

  always_comb begin
    md        = st_i.mode;
    dot       = st_i.dot;
    mns       = st_i.minus;
    ln        = st_i.line;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    t         = '0;
    swallow   = 1'b0;
    run_idle  = 1'b0;
    open_kind = KIND_NUM;
    ia        = idle_step(cmt_ch_i, 1'b0, cmt_ch_i);
    ib        = idle_step(char_i, 1'b1, cmt_ch_i);

    // resolve a held comment character first
    if (md == MODE_HELD) begin
      if ((char_i != CH_NUL) && (char_i == cmt_ch_i)) begin
        md      = MODE_CMT;
        swallow = 1'b1;
      end else begin
        md = ia.mode;
        if (ia.num_start) begin
          dot = 1'b0;
          mns = ia.minus_first;
        end
        if (ia.newline && (ln != LINE_MAX)) ln = ln + LINE_BITS'(1);
        if (ia.emit) begin
          r0 = mk_tok(ia.kind, ia.ch, 1'b1, ia.tok_end, ln, FAULT_NONE);
          n  = 2'd1;
        end
      end
    end

    if (!swallow) begin
      if (char_i == CH_NUL) begin
        // end of text: close what is open, then restart
        unique case (md)
          MODE_NUM, MODE_ID: begin
            open_kind = (md == MODE_NUM) ? KIND_NUM : KIND_ID;
            if (n != 2'd0) begin
              r0.tok_end = 1'b1;
              r1 = mk_tok(KIND_END, CH_NUL, 1'b1, 1'b1, ln, FAULT_NONE);
            end else begin
              r0 = mk_tok(open_kind, CH_NUL, 1'b0, 1'b1, ln, FAULT_NONE);
              r1 = mk_tok(KIND_END, CH_NUL, 1'b1, 1'b1, ln, FAULT_NONE);
            end
            n = 2'd2;
          end
          MODE_STR: begin
            t = mk_tok(KIND_STR, CH_NUL, 1'b0, 1'b1, ln, FAULT_STR);
            if (n == 2'd0) r0 = t; else r1 = t;
            n = n + 2'd1;
          end
          MODE_IDLE, MODE_CMT: begin
            t = mk_tok(KIND_END, CH_NUL, 1'b1, 1'b1, ln, FAULT_NONE);
            if (n == 2'd0) r0 = t; else r1 = t;
            n = n + 2'd1;
          end
          default: begin
            // halted: silent restart, a word from a held character stays
          end
        endcase
        md  = MODE_IDLE;
        dot = 1'b0;
        mns = 1'b0;
        ln  = LINE_FIRST;
      end else begin
        unique case (md)
          MODE_IDLE: begin
            run_idle = 1'b1;
          end
          MODE_NUM: begin
            if (is_digit(char_i) || (char_i == CH_DOT) || (char_i == CH_MINUS)) begin
              priority if ((char_i == CH_DOT) && dot) begin
                t  = mk_tok(KIND_NUM, char_i, 1'b0, 1'b1, ln, FAULT_DOT);
                md = MODE_HALT;
              end else if ((char_i == CH_MINUS) && mns) begin
                t  = mk_tok(KIND_NUM, char_i, 1'b0, 1'b1, ln, FAULT_MINUS);
                md = MODE_HALT;
              end else begin
                if (char_i == CH_DOT) dot = 1'b1;
                if (char_i == CH_MINUS) mns = 1'b1;
                t = mk_tok(KIND_NUM, char_i, 1'b0, 1'b0, ln, FAULT_NONE);
              end
              if (n == 2'd0) r0 = t; else r1 = t;
              n = n + 2'd1;
            end else begin
              // token closed by this byte: mark the last word or add an end mark
              if (n != 2'd0) begin
                r0.tok_end = 1'b1;
              end else begin
                r0 = mk_tok(KIND_NUM, CH_NUL, 1'b0, 1'b1, ln, FAULT_NONE);
                n  = 2'd1;
              end
              md       = MODE_IDLE;
              run_idle = 1'b1;
            end
          end
          MODE_ID: begin
            if (is_alnum(char_i)) begin
              t = mk_tok(KIND_ID, char_i, 1'b0, 1'b0, ln, FAULT_NONE);
              if (n == 2'd0) r0 = t; else r1 = t;
              n = n + 2'd1;
            end else begin
              if (n != 2'd0) begin
                r0.tok_end = 1'b1;
              end else begin
                r0 = mk_tok(KIND_ID, CH_NUL, 1'b0, 1'b1, ln, FAULT_NONE);
                n  = 2'd1;
              end
              md       = MODE_IDLE;
              run_idle = 1'b1;
            end
          end
          MODE_STR: begin
            t = mk_tok(KIND_STR, char_i, 1'b0, char_i == CH_QUOTE, ln, FAULT_NONE);
            if (n == 2'd0) r0 = t; else r1 = t;
            n = n + 2'd1;
            if (char_i == CH_QUOTE) md = MODE_IDLE;
            else if ((char_i == CH_LF) && (ln != LINE_MAX)) ln = ln + LINE_BITS'(1);
          end
          MODE_CMT: begin
            if (char_i == CH_LF) begin
              if (ln != LINE_MAX) ln = ln + LINE_BITS'(1);
              md = MODE_IDLE;
            end
          end
          default: begin
            md = st_i.mode == MODE_HALT ? MODE_HALT : md;
          end
        endcase

        // byte handled as a character between tokens
        if (run_idle) begin
          md = ib.mode;
          if (ib.num_start) begin
            dot = 1'b0;
            mns = ib.minus_first;
          end
          if (ib.newline && (ln != LINE_MAX)) ln = ln + LINE_BITS'(1);
          if (ib.emit) begin
            t = mk_tok(ib.kind, ib.ch, 1'b1, ib.tok_end, ln, FAULT_NONE);
            if (n == 2'd0) r0 = t; else r1 = t;
            n = n + 2'd1;
          end
        end
      end
    end

    st_o.mode  = md;
    st_o.dot   = dot;
    st_o.minus = mns;
    st_o.line  = ln;
    res_n_o    = n;
    res0_o     = r0;
    res1_o     = r1;
  end

endmodule

>>> rtl/core/stt_outq.sv
// small result queue: takes up to two words a cycle, hands out one while not stalled
// depends on stt_pkg; head entry drives the result channel directly
module stt_outq import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n_i,
  input  tok_t       push0_i,
  input  tok_t       push1_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output tok_t       head_o,
  output logic       full_o
);

  tok_t                 q_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_r;
  logic [QPTR_BITS-1:0] wr_nxt;
  logic [QPTR_BITS-1:0] wr1;
  logic [QPTR_BITS-1:0] rd_r;
  logic [QPTR_BITS-1:0] rd_nxt;
  logic [QCNT_BITS-1:0] cnt_r;
  logic [QCNT_BITS-1:0] cnt_nxt;
  logic                 pop;

  assign out_valid_o = (cnt_r != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = q_r[rd_r];
  // room for two more words keeps a byte with a double result safe
  assign full_o      = (cnt_r > QCNT_BITS'(QDEPTH - 2));

  // pointer and fill count
  always_comb begin
    wr1     = wr_r + QPTR_BITS'(1);
    wr_nxt  = wr_r + QPTR_BITS'(push_n_i);
    rd_nxt  = pop ? rd_r + QPTR_BITS'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_BITS'(push_n_i) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) q_r[wr_r] <= push0_i;
    if (push_n_i == 2'd2) q_r[wr1]  <= push1_i;
  end

endmodule

>>> rtl/core/source_text_tokenizer.sv
// top level of the source text tokenizer: scan state, comment register,
// step logic and result queue; depends on stt_pkg, stt_step, stt_outq
`include "assert_macros.svh"

// Takes one source byte per word on the input channel (byte 0 ends the text
// and restarts line counting) and emits one word per token character on the
// result channel, tagged with kind, start/end marks, line number and fault.
// A byte is taken every cycle while the four-entry result queue holds two
// words or fewer; a byte that closes a number or identifier can yield two
// words, so throughput is one byte per cycle except where the result side
// stalls or must drain those extra words at one per cycle. The user must
// write the comment character on the cfg channel (always ready, reset value
// '/') only while the block is idle; the block itself does not enforce it.
module source_text_tokenizer import stt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // source bytes
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_byte,
  // token words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_token_kind,
  output logic [7:0]           out_token_char,
  output logic                 out_token_start,
  output logic                 out_token_end,
  output logic [LINE_BITS-1:0] out_line_number,
  output logic [1:0]           out_fault_code,
  // comment character register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_comment_char
);

  scan_st_t   st_r;
  scan_st_t   st_nxt;
  logic [7:0] cc_r;
  logic       in_acc;
  logic       q_full;
  logic [1:0] step_n;
  logic [1:0] push_n;
  tok_t       res0;
  tok_t       res1;
  tok_t       head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_acc    = in_valid && !in_stall;
  assign push_n    = in_acc ? step_n : 2'd0;

  // comment character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= COMMENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cc_r <= cfg_comment_char;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= MODE_IDLE;
      st_r.dot   <= 1'b0;
      st_r.minus <= 1'b0;
      st_r.line  <= LINE_FIRST;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  stt_step u_step (
    .st_i     (st_r),
    .char_i   (in_char_byte),
    .cmt_ch_i (cc_r),
    .st_o     (st_nxt),
    .res_n_o  (step_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  stt_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_n_i    (push_n),
    .push0_i     (res0),
    .push1_i     (res1),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .head_o      (head),
    .full_o      (q_full)
  );

  // result fields
  assign out_token_kind  = head.kind;
  assign out_token_char  = head.ch;
  assign out_token_start = head.start;
  assign out_token_end   = head.tok_end;
  assign out_line_number = head.line;
  assign out_fault_code  = head.fault;

  // line counter starts at one and never wraps to zero
  `ASSERT_ALWAYS(a_line_nonzero, st_r.line != '0, "line counter reached zero")

  // end of text restarts the scanner
  `ASSERT_NXT(a_restart, in_acc && (in_char_byte == CH_NUL), (st_r.mode == MODE_IDLE) && (st_r.line == LINE_FIRST) && !st_r.dot && !st_r.minus, "byte 0 did not restart the scanner")

  // a number fault halts the scanner
  `ASSERT_NXT(a_fault_halt, in_acc && ((res0.fault == FAULT_DOT) || (res0.fault == FAULT_MINUS) || (res1.fault == FAULT_DOT) || (res1.fault == FAULT_MINUS)), st_r.mode == MODE_HALT, "number fault did not halt")

  // doubled comment character gives no word and enters comment mode
  `ASSERT_IMP(a_comment_open, in_acc && (st_r.mode == MODE_HELD) && (in_char_byte != CH_NUL) && (in_char_byte == cc_r), (step_n == 2'd0) ##1 (st_r.mode == MODE_CMT), "comment open mishandled")

endmodule
